[hw/rtl/mpurb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpurb_pkg
// Shared types and codes of the multi-port UART receive ring buffer.
// ----------------------------------------------------------------------------
package mpurb_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    ACT_IRQ   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLUSH = 2'd2
  } action_e;

  // Interrupt identification codes, IIR bits 3..1 (16550 numbering).
  typedef enum logic [2:0] {
    IIR_TX_EMPTY = 3'd1,
    IIR_RDA      = 3'd2,
    IIR_CTI      = 3'd6
  } iir_code_e;

  localparam int unsigned IIR_CODE_LSB  = 1;
  localparam int unsigned LSR_THRE_BIT  = 5;
  localparam int unsigned FILL_OUT_W    = 6;

  // Result fields held between the pointer stage and the output register.
  typedef struct packed {
    logic                  read_valid;
    logic [FILL_OUT_W-1:0] fill_count;
    logic                  timeout_seen;
    logic                  tx_empty;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/mpurb_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpurb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpurb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/multi_port_uart_rx_ring_buffer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_port_uart_rx_ring_buffer
// Per-port receive rings for a bank of 16550-style UARTs, one shared byte RAM.
// ----------------------------------------------------------------------------
// Each word on the input channel is an interrupt event, a read or a flush for
// one UART port, and yields exactly one result word. Items are taken at one
// per cycle unless the output stalls. On accept the port's head/tail pointers
// and flags (flip-flops) are updated and a push writes, or a pop reads, the
// shared ring RAM; once stage 1 advances, the RAM's registered read data
// joins the result in the output register. A pop always sees any earlier
// push because the RAM write lands at the accept edge. A ring holds at most
// RING_DEPTH-1 bytes; an RDA byte arriving at a full ring is dropped. Ring
// contents are not cleared at reset, only pointers and flags are. Items
// naming a port at or above PORT_COUNT change nothing and return all-zero
// fields. fill_count reports the low six bits.
// ----------------------------------------------------------------------------
module multi_port_uart_rx_ring_buffer #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned PORT_COUNT = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [1:0] port_i,
  input  wire logic [7:0] iir_value_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] line_status_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            read_valid_o,
  output logic [7:0]      read_byte_o,
  output logic [mpurb_pkg::FILL_OUT_W-1:0] fill_count_o,
  output logic            timeout_seen_o,
  output logic            tx_empty_o
);
  import mpurb_pkg::*;

  localparam int unsigned PTR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FILL_W   = PTR_W + 1;
  localparam int unsigned PIDX_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned RAM_DEPTH = PORT_COUNT * RING_DEPTH;
  localparam int unsigned ADDR_W   = $clog2(RAM_DEPTH);

  // Per-port pointers and status flags
  logic [PTR_W-1:0]      wptr_q [PORT_COUNT];
  logic [PTR_W-1:0]      rptr_q [PORT_COUNT];
  logic [PORT_COUNT-1:0] tmo_q;
  logic [PORT_COUNT-1:0] thre_q;

  // Stage 1 (between accept and output register)
  logic    s1_valid_q;
  result_t s1_res_q;

  // Output register
  logic    out_valid_q;
  result_t out_res_q;
  logic [7:0] out_byte_q;

  logic accept;
  logic s1_adv;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Pointer stage: decode the item against the addressed port's state.
  // ---------------------------------------------------------------------------
  logic              port_ok;
  logic [PIDX_W-1:0] pidx;
  logic [PTR_W-1:0]  wptr, rptr, wptr_inc, rptr_inc, wptr_d, rptr_d;
  logic              tmo_d, thre_d;
  logic              push, pop;
  iir_code_e         code;
  logic [FILL_W-1:0] fill_full;
  logic [31:0]       fill_wide;
  logic [ADDR_W-1:0] base;
  result_t           res_d;

  assign port_ok = (32'(port_i) < PORT_COUNT);
  assign pidx    = PIDX_W'(port_i);
  assign wptr    = port_ok ? wptr_q[pidx] : '0;
  assign rptr    = port_ok ? rptr_q[pidx] : '0;
  assign code    = iir_code_e'(iir_value_i[IIR_CODE_LSB +: 3]);

  // Wrap at RING_DEPTH, which need not be a power of two.
  assign wptr_inc = (wptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
  assign rptr_inc = (rptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);

  always_comb begin
    wptr_d = wptr;
    rptr_d = rptr;
    tmo_d  = port_ok ? tmo_q[pidx]  : 1'b0;
    thre_d = port_ok ? thre_q[pidx] : 1'b0;
    push   = 1'b0;
    pop    = 1'b0;
    case (action_e'(action_i))
      ACT_IRQ: begin
        case (code)
          IIR_RDA: begin
            if (wptr_inc != rptr) begin
              push   = 1'b1;
              wptr_d = wptr_inc;
            end
          end
          IIR_CTI:      tmo_d  = 1'b1;
          IIR_TX_EMPTY: thre_d = line_status_i[LSR_THRE_BIT];
          default: ;
        endcase
      end
      ACT_READ: begin
        if (wptr != rptr) begin
          pop    = 1'b1;
          rptr_d = rptr_inc;
        end
      end
      ACT_FLUSH: wptr_d = rptr;
      default: ;
    endcase
  end

  // Fill after the step
  assign fill_full = (wptr_d >= rptr_d)
                   ? {1'b0, wptr_d} - {1'b0, rptr_d}
                   : {1'b0, wptr_d} + FILL_W'(RING_DEPTH) - {1'b0, rptr_d};
  assign fill_wide = 32'(fill_full);

  always_comb begin
    res_d = '0;
    if (port_ok) begin
      res_d.read_valid   = pop;
      res_d.fill_count   = fill_wide[FILL_OUT_W-1:0];
      res_d.timeout_seen = tmo_d;
      res_d.tx_empty     = thre_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        wptr_q[i] <= '0;
        rptr_q[i] <= '0;
      end
      tmo_q  <= '0;
      thre_q <= '0;
    end else if (accept && port_ok) begin
      wptr_q[pidx] <= wptr_d;
      rptr_q[pidx] <= rptr_d;
      tmo_q[pidx]  <= tmo_d;
      thre_q[pidx] <= thre_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring RAM: port base plus slot; push writes at head, pop reads at tail.
  // ---------------------------------------------------------------------------
  logic [7:0] ram_rdata;

  assign base = ADDR_W'(32'(pidx) * RING_DEPTH);

  mpurb_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (accept && port_ok && push),
    .waddr_i (base + ADDR_W'(wptr)),
    .wdata_i (rx_byte_i),
    .re_i    (accept && port_ok && pop),
    .raddr_i (base + ADDR_W'(rptr)),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 and output register. RAM read data only changes on accept, which
  // needs stage 1 to move, so it stays put while stage 1 waits.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_res_q  <= s1_res_q;
      out_byte_q <= s1_res_q.read_valid ? ram_rdata : 8'h00;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_valid_o   = out_res_q.read_valid;
  assign read_byte_o    = out_byte_q;
  assign fill_count_o   = out_res_q.fill_count;
  assign timeout_seen_o = out_res_q.timeout_seen;
  assign tx_empty_o     = out_res_q.tx_empty;

endmodule
`default_nettype wire
